### rtl/fqtr_pkg.sv
package fqtr_pkg;

  // geometry limits and element size
  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int ELEMENT_BYTES = 4;

  // fixed field widths
  localparam int PIX_W     = 32;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int TURN_W    = 2;

  // derived widths
  localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int POS_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int PROD_W    = 2 * DIM_W;

  // stored elements keep 8*ELEMENT_BYTES bits
  localparam logic [PIX_W-1:0] PIXEL_MASK = (ELEMENT_BYTES >= 4) ? {PIX_W{1'b1}} :
    PIX_W'((64'd1 << (8 * ELEMENT_BYTES)) - 64'd1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TURNS = 2'd2;

  // rotation codes
  localparam logic [TURN_W-1:0] TURN_NONE = 2'd0;
  localparam logic [TURN_W-1:0] TURN_90   = 2'd1;
  localparam logic [TURN_W-1:0] TURN_180  = 2'd2;
  localparam logic [TURN_W-1:0] TURN_270  = 2'd3;

  // input kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // store access issued by the address generator
  typedef struct packed {
    logic              vld;    // a result word follows
    logic              wr;     // write the element into the store
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
    logic              rdy;    // frame_ready flag of the result
    logic              last;   // last_of_frame flag of the result
    logic              zero;   // result pixel forced to zero
  } fqtr_req_t;

  // zero reads as one, large values saturate
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

### rtl/frame_quarter_turn_rotator_top.sv
// Quarter-turn frame rotator.
// Input channel (in_valid/in_ready): each word carries in_kind and in_pixel.
// A load word (kind 0) writes the next source element in raster order into
// the frame store and gives no result; loads are dropped while a complete
// frame waits to be drained. A drain word (kind 1) gives one result word on
// the output channel (out_valid/out_ready): the next element of the rotated
// plane, with frame_ready and last_of_frame. A drain before the frame is
// complete gives a word of all zeros. After the last element a new frame
// starts loading.
// Configuration (cfg_we/cfg_index/cfg_data): frame width, frame height and
// quarter turns, written while the block is idle.
// A result word passes through the request register and then the result
// register after its drain word is accepted. One word is accepted every
// cycle while the output does not stall. The rate is set by the single-port
// frame memory, which takes one write or one read per cycle.
// Reset (rst_n, synchronous) empties the frame and the pipe; the store
// contents are not cleared. When out_ready is low with a result pending the
// whole pipe holds and in_ready drops.
module frame_quarter_turn_rotator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fqtr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fqtr_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [fqtr_pkg::PIX_W-1:0]          in_pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fqtr_pkg::PIX_W-1:0]          out_pixel,
  output logic                                out_frame_ready,
  output logic                                out_last_of_frame
);
  import fqtr_pkg::*;

  fqtr_req_t req;
  logic      adv;

  assign in_ready = adv;

  // counters, index math and store request
  fqtr_addr_gen u_addr_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_pixel  (in_pixel),
    .req_r     (req)
  );

  // frame memory and result register
  fqtr_frame_store u_frame_store (
    .clk               (clk),
    .rst_n             (rst_n),
    .req               (req),
    .adv               (adv),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel         (out_pixel),
    .out_frame_ready   (out_frame_ready),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

### rtl/fqtr_addr_gen.sv
module fqtr_addr_gen (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fqtr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fqtr_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic                                in_kind,
  input  logic [fqtr_pkg::PIX_W-1:0]          in_pixel,
  output fqtr_pkg::fqtr_req_t                 req_r
);
  import fqtr_pkg::*;

  logic [CFG_W-1:0]  width_r, height_r;
  logic [TURN_W-1:0] turns_r;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic              full_r, full_nxt;
  logic [POS_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  fqtr_req_t         req_nxt;

  logic [DIM_W-1:0]  w, h, ow, oh, a_sel, b_sel, row_x, col_x, col_inc;
  logic [PROD_W-1:0] total, idx;
  logic              accept, swap, in_range, is_last, can_write;
  logic [CNT_W-1:0]  cnt_after;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(256);
      height_r <= CFG_W'(256);
      turns_r  <= TURN_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   width_r  <= cfg_data;
        REG_FRAME_HEIGHT:  height_r <= cfg_data;
        REG_QUARTER_TURNS: turns_r  <= cfg_data[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // plane geometry
  always_comb begin
    w     = clamp_dim(width_r, MAX_WIDTH);
    h     = clamp_dim(height_r, MAX_HEIGHT);
    total = PROD_W'(w) * PROD_W'(h);
    swap  = turns_r[0];
    ow    = swap ? h : w;
    oh    = swap ? w : h;
    row_x = DIM_W'(row_r);
    col_x = DIM_W'(col_r);
  end

  // source index of the current output position: a * w + b
  always_comb begin
    case (turns_r)
      TURN_90: begin
        a_sel = h - DIM_W'(1) - col_x;
        b_sel = row_x;
      end
      TURN_180: begin
        a_sel = h - DIM_W'(1) - row_x;
        b_sel = w - DIM_W'(1) - col_x;
      end
      TURN_270: begin
        a_sel = col_x;
        b_sel = w - DIM_W'(1) - row_x;
      end
      default: begin
        a_sel = row_x;
        b_sel = col_x;
      end
    endcase
    idx = PROD_W'(a_sel) * PROD_W'(w) + PROD_W'(b_sel);
  end

  // frame sequencing and store request
  always_comb begin
    accept    = in_valid && adv;
    in_range  = (row_x < oh) && (col_x < ow);
    is_last   = (row_x == oh - DIM_W'(1)) && (col_x == ow - DIM_W'(1));
    col_inc   = col_x + DIM_W'(1);
    can_write = PROD_W'(load_cnt_r) < total;
    cnt_after = can_write ? load_cnt_r + CNT_W'(1) : load_cnt_r;

    load_cnt_nxt = load_cnt_r;
    full_nxt     = full_r;
    row_nxt      = row_r;
    col_nxt      = col_r;

    req_nxt       = req_r;
    req_nxt.vld   = 1'b0;
    req_nxt.wr    = 1'b0;
    req_nxt.wdata = in_pixel & PIXEL_MASK;

    if (accept) begin
      if (in_kind == KIND_LOAD) begin
        req_nxt.addr = load_cnt_r[ADDR_W-1:0];
        if (!full_r) begin
          req_nxt.wr   = can_write;
          load_cnt_nxt = cnt_after;
          if (PROD_W'(cnt_after) >= total) begin
            full_nxt = 1'b1;
          end
        end
      end else begin
        req_nxt.vld  = 1'b1;
        req_nxt.addr = idx[ADDR_W-1:0];
        if (!full_r) begin
          req_nxt.zero = 1'b1;
          req_nxt.rdy  = 1'b0;
          req_nxt.last = 1'b0;
        end else if (!in_range) begin
          // geometry shrank under a loaded frame: close it out
          req_nxt.zero = 1'b1;
          req_nxt.rdy  = 1'b1;
          req_nxt.last = 1'b1;
          load_cnt_nxt = '0;
          full_nxt     = 1'b0;
          row_nxt      = '0;
          col_nxt      = '0;
        end else begin
          req_nxt.zero = 1'b0;
          req_nxt.rdy  = 1'b1;
          req_nxt.last = is_last;
          if (is_last) begin
            load_cnt_nxt = '0;
            full_nxt     = 1'b0;
            row_nxt      = '0;
            col_nxt      = '0;
          end else if (col_inc >= ow) begin
            col_nxt = '0;
            row_nxt = row_r + POS_W'(1);
          end else begin
            col_nxt = col_inc[POS_W-1:0];
          end
        end
      end
    end
  end

  // state and request registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      full_r     <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
      req_r.vld  <= 1'b0;
      req_r.wr   <= 1'b0;
    end else if (adv) begin
      load_cnt_r <= load_cnt_nxt;
      full_r     <= full_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      req_r      <= req_nxt;
    end
  end

endmodule

### rtl/fqtr_frame_store.sv
module fqtr_frame_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fqtr_pkg::fqtr_req_t          req,
  output logic                         adv,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fqtr_pkg::PIX_W-1:0]   out_pixel,
  output logic                         out_frame_ready,
  output logic                         out_last_of_frame
);
  import fqtr_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;
  logic             out_valid_r, rdy_r, last_r, zero_r;

  // the whole pipe moves when the result register is free or being taken
  assign adv = !out_valid_r || out_ready;

  // frame memory, one access per cycle
  always_ff @(posedge clk) begin
    if (adv) begin
      if (req.wr) begin
        mem[req.addr] <= req.wdata;
      end
      if (req.vld) begin
        rd_data_r <= mem[req.addr];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= req.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdy_r  <= req.rdy;
      last_r <= req.last;
      zero_r <= req.zero;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel         = zero_r ? '0 : rd_data_r;
  assign out_frame_ready   = rdy_r;
  assign out_last_of_frame = last_r;

endmodule
